// ===== sv/ifba_pkg.sv =====
// Shared constants, codes and types for the frame block averager.
`timescale 1ns / 1ps

package ifba_pkg;

	// Frame layout and field widths
	localparam int FRAME_BYTES = 14;
	localparam int NUM_CH      = 7;
	localparam int BYTE_W      = 8;
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = 21;
	localparam int CNT_W       = 5;
	localparam int CH_W        = 3;
	localparam int POS_W       = 4;
	localparam int ERR_W       = 2;

	// Averaging count after reset
	localparam logic [CNT_W-1:0] CNT_RESET = 5'd4;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Bus error codes on the input side
	localparam logic [ERR_W-1:0] BUS_OK        = 2'd0;
	localparam logic [ERR_W-1:0] BUS_ADDR_FAIL = 2'd1;

	// Status codes on the result side
	localparam logic [ERR_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [ERR_W-1:0] STATUS_ADDR_FAIL = 2'd1;
	localparam logic [ERR_W-1:0] STATUS_RX_FAIL   = 2'd2;
	localparam logic [ERR_W-1:0] STATUS_UNUSED    = 2'd3;

	// Saturation limits on the quotient magnitude and the clamped outputs
	localparam logic [SUM_W-1:0]    MAG_POS_LIM = 21'd32767;
	localparam logic [SUM_W-1:0]    MAG_NEG_LIM = 21'd32768;
	localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAT_NEG     = 16'h8000;

	// Command passed from front to back
	typedef struct packed {
		logic                       is_err;
		logic [ERR_W-1:0]           status;
		logic [CH_W-1:0]            ch;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
	} op_t;

	// Seven averages, channel 0 in the low slot
	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] avg_vec_t;

endpackage

// ===== sv/imu_frame_block_averager_unit.sv =====
// Top level: frame block averager with configuration register and checks.
// A bus-error transfer passes through the command queue and then the result register; the frame
// that ends a run passes through the queue, then the shared 1-bit-per-cycle divider for each of the
// 7 channels in turn, then the emit state, before its result is registered.
// Throughput: one byte per cycle while the 4-entry command queue has room; during the
// run-end divide the back end drains nothing and the queue then stalls input.
// Reset (async, active low): count 4, sums, frame count and held averages zero, queue empty.
`timescale 1ns / 1ps

module imu_frame_block_averager_unit #(
	parameter int QUEUE_DEPTH = ifba_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ifba_pkg::CNT_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ifba_pkg::BYTE_W-1:0]         data_byte,
	input  logic [ifba_pkg::ERR_W-1:0]          bus_error,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ifba_pkg::ERR_W-1:0]          status,
	output logic signed [ifba_pkg::SAMPLE_W-1:0] accel_x,
	output logic signed [ifba_pkg::SAMPLE_W-1:0] accel_y,
	output logic signed [ifba_pkg::SAMPLE_W-1:0] accel_z,
	output logic signed [ifba_pkg::SAMPLE_W-1:0] temperature,
	output logic signed [ifba_pkg::SAMPLE_W-1:0] gyro_x,
	output logic signed [ifba_pkg::SAMPLE_W-1:0] gyro_y,
	output logic signed [ifba_pkg::SAMPLE_W-1:0] gyro_z
);

	logic [ifba_pkg::CNT_W-1:0] count_q;
	logic                       push;
	ifba_pkg::op_t              push_op;
	logic                       pop;
	ifba_pkg::op_t              pop_op;
	logic                       q_full;
	logic                       q_empty;
	ifba_pkg::avg_vec_t         avg;

	// Averaging count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ifba_pkg::CNT_RESET;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	ifba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.bus_error (bus_error),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op)
	);

	ifba_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	ifba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avg_count (count_q),
		.q_empty   (q_empty),
		.q_op      (pop_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.avg       (avg)
	);

	assign accel_x     = avg[0];
	assign accel_y     = avg[1];
	assign accel_z     = avg[2];
	assign temperature = avg[3];
	assign gyro_x      = avg[4];
	assign gyro_y      = avg[5];
	assign gyro_z      = avg[6];

	// Front never writes a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("command pushed into full queue");

	// Back never reads an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_empty)
		else $error("command popped from empty queue");

	// Status code three is never produced
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != ifba_pkg::STATUS_UNUSED))
		else $error("result carries unused status code");

endmodule

// ===== sv/ifba_front.sv =====
// Front end: pairs bytes into samples and classifies each transfer into a command.
`timescale 1ns / 1ps

module ifba_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ifba_pkg::BYTE_W-1:0]         data_byte,
	input  logic [ifba_pkg::ERR_W-1:0]          bus_error,
	input  logic                                q_full,
	output logic                                push,
	output ifba_pkg::op_t                       push_op
);

	localparam logic [ifba_pkg::POS_W-1:0] LAST_POS =
		ifba_pkg::POS_W'(ifba_pkg::FRAME_BYTES - 1);

	logic [ifba_pkg::POS_W-1:0]  pos_q;
	logic [ifba_pkg::BYTE_W-1:0] pend_q;
	logic                        accept;
	logic                        is_err;
	logic                        frame_end;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign is_err    = (bus_error != ifba_pkg::BUS_OK);
	assign frame_end = (pos_q == LAST_POS);

	// Classify: error command, or a completed sample on the low byte
	always_comb begin
		push    = 1'b0;
		push_op = '0;
		if (accept) begin
			if (is_err) begin
				push           = 1'b1;
				push_op.is_err = 1'b1;
				push_op.status = (bus_error == ifba_pkg::BUS_ADDR_FAIL) ?
					ifba_pkg::STATUS_ADDR_FAIL : ifba_pkg::STATUS_RX_FAIL;
			end else if (pos_q[0]) begin
				push              = 1'b1;
				push_op.ch        = pos_q[ifba_pkg::POS_W-1:1];
				push_op.sample    = {pend_q, data_byte};
				push_op.frame_end = frame_end;
			end
		end
	end

	// Byte position and pending high byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (is_err) begin
				pos_q  <= '0;
				pend_q <= '0;
			end else if (!pos_q[0]) begin
				pend_q <= data_byte;
				pos_q  <= pos_q + 1'b1;
			end else begin
				pos_q <= frame_end ? '0 : pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/ifba_queue.sv =====
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module ifba_queue #(
	parameter int DEPTH = ifba_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ifba_pkg::op_t push_op,
	input  logic          pop,
	output ifba_pkg::op_t pop_op,
	output logic          full,
	output logic          empty
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ifba_pkg::op_t    mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == FULL_CNT);
	assign empty  = (cnt_q == '0);
	assign pop_op = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ifba_back.sv =====
// Back end: channel sums, frame counting, serial divide and the result register.
`timescale 1ns / 1ps

module ifba_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [ifba_pkg::CNT_W-1:0]          avg_count,
	input  logic                                q_empty,
	input  ifba_pkg::op_t                       q_op,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ifba_pkg::ERR_W-1:0]          status,
	output ifba_pkg::avg_vec_t                  avg
);

	localparam int SUM_W  = ifba_pkg::SUM_W;
	localparam int CNT_W  = ifba_pkg::CNT_W;
	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
	localparam logic [ifba_pkg::CH_W-1:0] LAST_CH = ifba_pkg::CH_W'(ifba_pkg::NUM_CH - 1);

	// Sequencer states
	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_STORE = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]                       state_q;
	logic [CNT_W-1:0]                 frames_q;
	logic signed [SUM_W-1:0]          sums_q [ifba_pkg::NUM_CH];
	ifba_pkg::avg_vec_t               held_q;
	logic [ifba_pkg::CH_W-1:0]        ch_q;
	logic [STEP_W-1:0]                step_q;
	logic                             neg_q;
	logic [SUM_W-1:0]                 quo_q;
	logic [CNT_W-1:0]                 rem_q;
	logic [CNT_W-1:0]                 div_q;
	logic                             out_valid_q;
	logic [ifba_pkg::ERR_W-1:0]       status_q;
	ifba_pkg::avg_vec_t               avg_q;

	logic [CNT_W-1:0]                 cnt_eff;
	logic [CNT_W-1:0]                 fd_next;
	logic                             run_done;
	logic                             out_free;
	logic                             err_load;
	logic                             emit_load;
	logic [ifba_pkg::CH_W-1:0]        rd_idx;
	logic signed [SUM_W-1:0]          sum_rd;
	logic signed [SUM_W-1:0]          sample_ext;
	logic signed [SUM_W-1:0]          add_sum;
	logic [SUM_W-1:0]                 mag;
	logic [CNT_W:0]                   rem_sh;
	logic [CNT_W:0]                   rem_sub;
	logic                             quo_bit;
	logic [SUM_W-1:0]                 quo_neg;
	logic [ifba_pkg::SAMPLE_W-1:0]    avg_new;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_RUN) && !q_empty && (!q_op.is_err || out_free);
	assign err_load  = pop && q_op.is_err;
	assign emit_load = (state_q == ST_EMIT) && out_free;

	// A count of zero acts as one
	assign cnt_eff  = (avg_count == '0) ? CNT_W'(1) : avg_count;
	assign fd_next  = frames_q + 1'b1;
	assign run_done = (fd_next >= cnt_eff);

	// Single read port on the sums: command channel while running, divide channel otherwise
	assign rd_idx     = (state_q == ST_RUN) ? q_op.ch : ch_q;
	assign sum_rd     = sums_q[rd_idx];
	assign sample_ext = {{(SUM_W - ifba_pkg::SAMPLE_W){q_op.sample[ifba_pkg::SAMPLE_W-1]}},
		q_op.sample};
	assign add_sum    = sum_rd + sample_ext;
	assign mag        = sum_rd[SUM_W-1] ? (~sum_rd + 1'b1) : sum_rd;

	// One restoring divide step
	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign quo_bit = (rem_sh >= {1'b0, div_q});
	assign rem_sub = rem_sh - {1'b0, div_q};

	// Sign restore and clamp to 16 bits
	assign quo_neg = ~quo_q + 1'b1;
	always_comb begin
		if (neg_q) begin
			avg_new = (quo_q > ifba_pkg::MAG_NEG_LIM) ? ifba_pkg::SAT_NEG :
				quo_neg[ifba_pkg::SAMPLE_W-1:0];
		end else begin
			avg_new = (quo_q > ifba_pkg::MAG_POS_LIM) ? ifba_pkg::SAT_POS :
				quo_q[ifba_pkg::SAMPLE_W-1:0];
		end
	end

	// Sequencer, sums, frame count and held averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			frames_q <= '0;
			held_q   <= '0;
			ch_q     <= '0;
			step_q   <= '0;
			neg_q    <= 1'b0;
			quo_q    <= '0;
			rem_q    <= '0;
			div_q    <= CNT_W'(1);
			for (int i = 0; i < ifba_pkg::NUM_CH; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						if (q_op.is_err) begin
							frames_q <= '0;
							for (int i = 0; i < ifba_pkg::NUM_CH; i++) begin
								sums_q[i] <= '0;
							end
						end else begin
							sums_q[q_op.ch] <= add_sum;
							if (q_op.frame_end) begin
								if (run_done) begin
									frames_q <= '0;
									div_q    <= cnt_eff;
									ch_q     <= '0;
									state_q  <= ST_LOAD;
								end else begin
									frames_q <= fd_next;
								end
							end
						end
					end
				end
				ST_LOAD: begin
					neg_q   <= sum_rd[SUM_W-1];
					quo_q   <= mag;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= quo_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
					quo_q  <= {quo_q[SUM_W-2:0], quo_bit};
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					held_q[ch_q] <= avg_new;
					if (ch_q == LAST_CH) begin
						state_q <= ST_EMIT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						for (int i = 0; i < ifba_pkg::NUM_CH; i++) begin
							sums_q[i] <= '0;
						end
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (err_load || emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (err_load) begin
			status_q <= q_op.status;
			avg_q    <= held_q;
		end else if (emit_load) begin
			status_q <= ifba_pkg::STATUS_OK;
			avg_q    <= held_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign avg       = avg_q;

endmodule

// ===== tb/ifba_average_checker.sv =====
// Checker for the frame block averager: predicts each result from the observed transfers.
`timescale 1ns / 1ps

module ifba_average_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [ifba_pkg::CNT_W-1:0]           cfg_wr_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [ifba_pkg::BYTE_W-1:0]          data_byte,
	input  logic [ifba_pkg::ERR_W-1:0]           bus_error,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [ifba_pkg::ERR_W-1:0]           status,
	input  logic signed [ifba_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [ifba_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [ifba_pkg::SAMPLE_W-1:0] accel_z,
	input  logic signed [ifba_pkg::SAMPLE_W-1:0] temperature,
	input  logic signed [ifba_pkg::SAMPLE_W-1:0] gyro_x,
	input  logic signed [ifba_pkg::SAMPLE_W-1:0] gyro_y,
	input  logic signed [ifba_pkg::SAMPLE_W-1:0] gyro_z,
	output int                                   fail_count,
	output int                                   n_expected
);

	typedef struct packed {
		logic [ifba_pkg::ERR_W-1:0] status;
		ifba_pkg::avg_vec_t         avg;
	} avg_result_t;

	// Shadow of the block state
	logic [ifba_pkg::CNT_W-1:0]  avg_count;
	logic [ifba_pkg::POS_W-1:0]  byte_pos;
	logic [ifba_pkg::BYTE_W-1:0] high_byte;
	logic [ifba_pkg::CNT_W-1:0]  frame_cnt;
	int                          ch_sum [ifba_pkg::NUM_CH];
	ifba_pkg::avg_vec_t          last_avg;

	avg_result_t pending_averages [$];
	int          mismatches = 0;

	string ch_name [ifba_pkg::NUM_CH] = '{"accel_x", "accel_y", "accel_z", "temperature",
		"gyro_x", "gyro_y", "gyro_z"};

	function automatic logic [ifba_pkg::SAMPLE_W-1:0] clamp_sample(input int v);
		if (v > 32767)
			return ifba_pkg::SAT_POS;
		if (v < -32768)
			return ifba_pkg::SAT_NEG;
		return v[ifba_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic clear_run();
		byte_pos  = '0;
		high_byte = '0;
		frame_cnt = '0;
		foreach (ch_sum[c])
			ch_sum[c] = 0;
	endtask

	// Fold one accepted byte (or bus error) into the running sums
	task automatic accumulate_byte(input logic [ifba_pkg::BYTE_W-1:0] b,
		input logic [ifba_pkg::ERR_W-1:0] e);
		logic signed [ifba_pkg::SAMPLE_W-1:0] sample;
		int                                   divisor;
		avg_result_t                          r;
		if (e != ifba_pkg::BUS_OK) begin
			clear_run();
			r.status = (e == ifba_pkg::BUS_ADDR_FAIL) ? ifba_pkg::STATUS_ADDR_FAIL :
				ifba_pkg::STATUS_RX_FAIL;
			r.avg    = last_avg;
			pending_averages.push_back(r);
			return;
		end
		if (!byte_pos[0]) begin
			high_byte = b;
		end else begin
			sample = {high_byte, b};
			ch_sum[byte_pos[ifba_pkg::POS_W-1:1]] += sample;
		end
		if (byte_pos != ifba_pkg::POS_W'(ifba_pkg::FRAME_BYTES - 1)) begin
			byte_pos = byte_pos + 1'b1;
			return;
		end
		// frame boundary
		byte_pos  = '0;
		frame_cnt = frame_cnt + 1'b1;
		divisor   = (avg_count == '0) ? 1 : int'(avg_count);
		if (int'(frame_cnt) < divisor)
			return;
		for (int c = 0; c < ifba_pkg::NUM_CH; c++)
			last_avg[c] = clamp_sample(ch_sum[c] / divisor);
		clear_run();
		r.status = ifba_pkg::STATUS_OK;
		r.avg    = last_avg;
		pending_averages.push_back(r);
	endtask

	task automatic compare_result();
		avg_result_t        r;
		ifba_pkg::avg_vec_t got;
		got = {gyro_z, gyro_y, gyro_x, temperature, accel_z, accel_y, accel_x};
		if (pending_averages.size() == 0) begin
			$display("%0t ERROR unexpected result: expected none, got status %0d", $time, status);
			mismatches++;
			return;
		end
		r = pending_averages.pop_front();
		if (status !== r.status) begin
			$display("%0t ERROR status: expected %0d, got %0d", $time, r.status, status);
			mismatches++;
		end
		for (int c = 0; c < ifba_pkg::NUM_CH; c++) begin
			if (got[c] !== r.avg[c]) begin
				$display("%0t ERROR %s: expected %0d, got %0d", $time, ch_name[c],
					$signed(r.avg[c]), $signed(got[c]));
				mismatches++;
			end
		end
	endtask

	// Config write, input transfer, output transfer, in that order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count = ifba_pkg::CNT_RESET;
			last_avg  = '0;
			clear_run();
			pending_averages.delete();
		end else begin
			if (cfg_wr_en)
				avg_count = cfg_wr_data;
			if (in_valid && !in_stall)
				accumulate_byte(data_byte, bus_error);
			if (out_valid && !out_stall)
				compare_result();
		end
		n_expected <= pending_averages.size();
		fail_count <= mismatches;
	end

endmodule

// ===== tb/imu_frame_block_averager_unit_tb.sv =====
// Testbench top: stimulus, stall patterns and verdict for the frame block averager.
`timescale 1ns / 1ps

module imu_frame_block_averager_unit_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 250;
	localparam int HOLD_CYCLES  = 1500;

	// Error codes that the package does not name
	localparam logic [ifba_pkg::ERR_W-1:0] BUS_RX_FAIL   = 2'd2;
	localparam logic [ifba_pkg::ERR_W-1:0] BUS_UNDEFINED = 2'd3;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum {FRAME_MIX, FRAME_MAX, FRAME_MIN} frame_style_t;

	logic                                 clk         = 1'b0;
	logic                                 arst_n      = 1'b0;
	logic                                 cfg_wr_en   = 1'b0;
	logic [ifba_pkg::CNT_W-1:0]           cfg_wr_data = '0;
	logic                                 in_valid    = 1'b0;
	logic                                 in_stall;
	logic [ifba_pkg::BYTE_W-1:0]          data_byte   = '0;
	logic [ifba_pkg::ERR_W-1:0]           bus_error   = ifba_pkg::BUS_OK;
	logic                                 out_valid;
	logic                                 out_stall   = 1'b0;
	logic [ifba_pkg::ERR_W-1:0]           status;
	logic signed [ifba_pkg::SAMPLE_W-1:0] accel_x, accel_y, accel_z, temperature;
	logic signed [ifba_pkg::SAMPLE_W-1:0] gyro_x, gyro_y, gyro_z;

	int fail_count;
	int n_expected;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_toggle    = 1'b0;
	logic hold_seen      = 1'b0;
	int   hold_left      = 0;
	int   cycle_cnt      = 0;

	logic [ifba_pkg::ERR_W-1:0] err_codes [3] = '{ifba_pkg::BUS_ADDR_FAIL, BUS_RX_FAIL,
		BUS_UNDEFINED};

	imu_frame_block_averager_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.bus_error   (bus_error),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.temperature (temperature),
		.gyro_x      (gyro_x),
		.gyro_y      (gyro_y),
		.gyro_z      (gyro_z)
	);

	ifba_average_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.bus_error   (bus_error),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.temperature (temperature),
		.gyro_x      (gyro_x),
		.gyro_y      (gyro_y),
		.gyro_z      (gyro_z),
		.fail_count  (fail_count),
		.n_expected  (n_expected)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// One input transfer, after a random idle gap
	task automatic send_item(input logic [ifba_pkg::BYTE_W-1:0] b,
		input logic [ifba_pkg::ERR_W-1:0] e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		bus_error <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering, wait for every expected result, then let the divider settle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_expected != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [ifba_pkg::CNT_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// One burst frame; with err_pct chance it is cut short by a bus error
	task automatic send_frame(input frame_style_t style, input int err_pct);
		logic [ifba_pkg::BYTE_W-1:0]   bytes [ifba_pkg::FRAME_BYTES];
		logic [ifba_pkg::SAMPLE_W-1:0] s;
		int                            cut;
		for (int k = 0; k < ifba_pkg::NUM_CH; k++) begin
			case (style)
				FRAME_MAX: s = 16'h7FFF;
				FRAME_MIN: s = 16'h8000;
				default: begin
					case ($urandom_range(9))
						0: s = 16'h7FFF;
						1: s = 16'h8000;
						2: s = 16'hFFFF;
						3: s = 16'h0000;
						default: s = ifba_pkg::SAMPLE_W'($urandom);
					endcase
				end
			endcase
			bytes[2*k]   = s[15:8];
			bytes[2*k+1] = s[7:0];
		end
		cut = ($urandom_range(99) < err_pct) ? $urandom_range(ifba_pkg::FRAME_BYTES - 1) :
			ifba_pkg::FRAME_BYTES;
		for (int i = 0; i < ifba_pkg::FRAME_BYTES; i++) begin
			if (i == cut) begin
				send_item(ifba_pkg::BYTE_W'($urandom), err_codes[$urandom_range(2)]);
				return;
			end
			send_item(bytes[i], ifba_pkg::BUS_OK);
		end
	endtask

	task automatic run_phase(input logic [ifba_pkg::CNT_W-1:0] cnt, input idle_mode_t mode,
		input int frames, input frame_style_t style, input int err_pct);
		settle();
		write_count(cnt);
		send_idle_pct  = (mode == IDLE_SEND) ? 77 : (mode == IDLE_BOTH) ? 38 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 77 : (mode == IDLE_BOTH) ? 38 : 0;
		repeat (frames) send_frame(style, err_pct);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every error code on zero held averages
		send_item(8'hA5, ifba_pkg::BUS_ADDR_FAIL);
		send_item(8'hFF, BUS_RX_FAIL);
		send_item(8'h00, BUS_UNDEFINED);
		settle();
		write_count(5'd1);
		// Single-frame run with extreme samples
		send_item(8'h7F, ifba_pkg::BUS_OK); send_item(8'hFF, ifba_pkg::BUS_OK);
		send_item(8'h80, ifba_pkg::BUS_OK); send_item(8'h00, ifba_pkg::BUS_OK);
		send_item(8'hFF, ifba_pkg::BUS_OK); send_item(8'hFF, ifba_pkg::BUS_OK);
		send_item(8'h00, ifba_pkg::BUS_OK); send_item(8'h00, ifba_pkg::BUS_OK);
		send_item(8'h00, ifba_pkg::BUS_OK); send_item(8'h01, ifba_pkg::BUS_OK);
		send_item(8'h80, ifba_pkg::BUS_OK); send_item(8'h01, ifba_pkg::BUS_OK);
		send_item(8'h7F, ifba_pkg::BUS_OK); send_item(8'hFE, ifba_pkg::BUS_OK);
		// Partial frame aborted mid-sample, then held averages reported again
		send_item(8'h12, ifba_pkg::BUS_OK); send_item(8'h34, ifba_pkg::BUS_OK);
		send_item(8'h56, ifba_pkg::BUS_OK);
		send_item(8'hFF, BUS_RX_FAIL);
		send_item(8'h5A, ifba_pkg::BUS_ADDR_FAIL);

		// Partial long run of full-scale samples, then a count drop forces saturation
		run_phase(5'd16, IDLE_NONE, 4, FRAME_MAX, 0);
		run_phase(5'd1, IDLE_SEND, 6, FRAME_MIX, 10);
		run_phase(5'd16, IDLE_NONE, 4, FRAME_MIN, 0);
		// Count of zero behaves as one
		run_phase(5'd0, IDLE_RECV, 6, FRAME_MIX, 10);
		run_phase(5'd2, IDLE_BOTH, 8, FRAME_MIX, 10);
		// Counts above sixteen
		run_phase(5'd31, IDLE_NONE, 31, FRAME_MIX, 0);
		run_phase(5'd17, IDLE_SEND, 17, FRAME_MIX, 3);
		run_phase(5'd3, IDLE_RECV, 9, FRAME_MIX, 10);

		// Receiver holds off long enough for the block to back up into its input
		settle();
		hold_toggle = ~hold_toggle;
		run_phase(5'd1, IDLE_NONE, 8, FRAME_MIX, 0);

		run_phase(5'd5, IDLE_BOTH, 8, FRAME_MIX, 10);
		run_phase(5'd4, IDLE_SEND, 8, FRAME_MIX, 10);

		settle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
